// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/fhm61_pkg.sv
// Types and constants for the binary64 hash modulo 2^61-1.
// No dependencies.
package fhm61_pkg;

  localparam int unsigned DATA_W   = 64;
  localparam int unsigned HASH_W   = 61;
  localparam int unsigned MANT_W   = 53;
  localparam int unsigned FRAC_W   = 52;
  localparam int unsigned EXP_W    = 11;
  localparam int unsigned ROT_W    = 6;

  localparam logic [EXP_W-1:0]  EXP_SPECIAL = 11'h7FF;
  // (e - 1075) mod 61 == (e + 23) mod 61; subnormals behave as e == 1
  localparam logic [11:0]       ROT_OFFSET  = 12'd23;
  localparam logic [7:0]        HMOD_X1     = 8'd61;
  localparam logic [7:0]        HMOD_X2     = 8'd122;
  localparam logic [DATA_W-1:0] HASH_INF    = 64'd314159;

  typedef struct packed {
    logic neg;
    logic nan;
    logic inf;
  } fhm61_flags_t;

endpackage

// File: rtl/core/float_hash_mod_mersenne61.sv
// Hash of a binary64 bit pattern modulo the Mersenne prime 2^61-1.
// Depends on fhm61_pkg.
//
// Four-stage pipeline: decode and fold of the exponent, reduction of the
// rotation amount mod 61, 61-bit barrel rotation of the mantissa, then sign
// negation and special-value select into the output register. One item is
// accepted per cycle while in_tready is high. Each stage holds only while the
// stage after it is full and stalled, so gaps close up.
module float_hash_mod_mersenne61
  import fhm61_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // [63:0] value_bits
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata   // [63:0] hash_value
);

  logic v1_r, v2_r, v3_r, out_valid_r;
  logic en1, en2, en3, out_en;

  fhm61_flags_t flags1_r, flags2_r, flags3_r;
  logic [MANT_W-1:0] mant1_r, mant2_r;
  logic [7:0]        fold1_r;
  logic [ROT_W-1:0]  rot2_r;
  logic [HASH_W-1:0] mag3_r;
  logic [DATA_W-1:0] out_data_r;

  assign out_en    = !out_valid_r || out_tready;
  assign en3       = !v3_r || out_en;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;

  // stage 1: decode
  logic [EXP_W-1:0]  ex;
  logic [FRAC_W-1:0] frac;
  logic [EXP_W-1:0]  ex_eff;
  logic [11:0]       ex_sum;
  logic [7:0]        fold_nxt;
  fhm61_flags_t      flags_nxt;

  always_comb begin
    ex            = in_tdata[62:52];
    frac          = in_tdata[FRAC_W-1:0];
    ex_eff        = (ex == '0) ? 11'd1 : ex;
    ex_sum        = {1'b0, ex_eff} + ROT_OFFSET;
    // 64 == 3 mod 61
    fold_nxt      = 8'({2'b0, ex_sum[11:6]} * 8'd3) + {2'b0, ex_sum[5:0]};
    flags_nxt.neg = in_tdata[63];
    flags_nxt.nan = (ex == EXP_SPECIAL) && (frac != '0);
    flags_nxt.inf = (ex == EXP_SPECIAL) && (frac == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_tvalid;
    end
    if (en1) begin
      flags1_r <= flags_nxt;
      mant1_r  <= {(ex != '0), frac};
      fold1_r  <= fold_nxt;
    end
  end

  // stage 2: rotation amount mod 61
  logic [7:0] rot_full;

  always_comb begin
    priority if (fold1_r >= HMOD_X2) begin
      rot_full = fold1_r - HMOD_X2;
    end else if (fold1_r >= HMOD_X1) begin
      rot_full = fold1_r - HMOD_X1;
    end else begin
      rot_full = fold1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
    if (en2) begin
      flags2_r <= flags1_r;
      mant2_r  <= mant1_r;
      rot2_r   <= rot_full[ROT_W-1:0];
    end
  end

  // stage 3: rotate left within 61 bits
  logic [HASH_W-1:0]   m61;
  logic [2*HASH_W-1:0] rot_dbl;

  always_comb begin
    m61     = {{(HASH_W-MANT_W){1'b0}}, mant2_r};
    rot_dbl = {m61, m61} << rot2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
    if (en3) begin
      flags3_r <= flags2_r;
      mag3_r   <= rot_dbl[2*HASH_W-1:HASH_W];
    end
  end

  // stage 4: sign and special values
  logic [DATA_W-1:0] mag64, signed64, res_nxt;

  always_comb begin
    mag64    = {{(DATA_W-HASH_W){1'b0}}, mag3_r};
    signed64 = flags3_r.neg ? (~mag64 + 64'd1) : mag64;
    if (signed64 == '1) begin
      signed64 = ~64'd1;
    end
    priority if (flags3_r.nan) begin
      res_nxt = '0;
    end else if (flags3_r.inf) begin
      res_nxt = flags3_r.neg ? (~HASH_INF + 64'd1) : HASH_INF;
    end else begin
      res_nxt = signed64;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= v3_r;
    end
    if (out_en) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: rtl/core/fhm61_checker.sv
// Port-level checks for float_hash_mod_mersenne61, bound into that module.
// Depends on fhm61_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fhm61_checker
  import fhm61_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [DATA_W-1:0] out_tdata
);

  `ASSERT_CLK_RST(a_never_all_ones, clk, rst_n, out_tvalid |-> (out_tdata != '1), "hash all ones")
  `ASSERT_CLK_RST(a_stall_holds, clk, rst_n, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)), "stalled item changed")
  `ASSERT_CLK(a_reset_empty, clk, !rst_n |=> !out_tvalid, "item out of reset")
  `ASSERT_CLK_RST(a_flow_through, clk, rst_n, out_tready |-> in_tready, "input stalled with free output")

endmodule

bind float_hash_mod_mersenne61 fhm61_checker u_fhm61_checker (.*);

// File: tb/tb_top.sv
// Self-checking testbench for float_hash_mod_mersenne61 (binary64 hash mod 2^61-1).
// Depends on fhm61_pkg and the float_hash_mod_mersenne61 RTL; a built-in predictor
// computes each expected hash, which is compared in order against the result stream.
module tb_top;
  import fhm61_pkg::*;

  localparam logic [63:0] HMOD       = 64'h1FFF_FFFF_FFFF_FFFF;
  localparam int          BIAS_SHIFT = 1075;
  localparam int          SUBN_SHIFT = -1074;
  localparam int          ROT_MOD    = 61;
  localparam int          MAX_REPORT = 10;
  localparam int          RAND_ITEMS = 1900;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;

  logic [63:0] pending_hashes[$];
  int          send_gap_pct = 0;
  int          sink_stall_pct = 0;
  int          mismatches = 0;
  int          items_sent = 0;
  int          hashes_checked = 0;
  int          special_items = 0;

  float_hash_mod_mersenne61 uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  function automatic logic [63:0] predict_hash(input logic [63:0] bits);
    logic        neg;
    logic [10:0] expo;
    logic [51:0] frac;
    logic [63:0] mant;
    logic [63:0] mag;
    int          k;
    int          r;
    neg  = bits[63];
    expo = bits[62:52];
    frac = bits[51:0];
    if (expo == EXP_SPECIAL) begin
      if (frac != '0) return '0;
      return neg ? (64'd0 - HASH_INF) : HASH_INF;
    end
    if (expo == '0) begin
      mant = {12'd0, frac};
      k = SUBN_SHIFT;
    end else begin
      mant = {11'd0, 1'b1, frac};
      k = int'(expo) - BIAS_SHIFT;
    end
    r = k % ROT_MOD;
    if (r < 0) r += ROT_MOD;
    if (r == 0) mag = mant;
    else mag = ((mant << r) & HMOD) | (mant >> (ROT_MOD - r));
    if (neg) mag = 64'd0 - mag;
    if (mag == '1) mag = '1 - 64'd1;
    return mag;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_value(input logic [63:0] bits);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= bits;
    do @(posedge clk); while (!in_tready);
    pending_hashes.push_back(predict_hash(bits));
    items_sent++;
    if (bits[62:52] == EXP_SPECIAL || bits[62:52] == '0) special_items++;
    @(negedge clk);
  endtask

  function automatic logic [63:0] make_float(input logic sgn, input logic [10:0] expo,
                                             input logic [51:0] frac);
    return {sgn, expo, frac};
  endfunction

  function automatic logic [63:0] random_float();
    logic        sgn;
    logic [10:0] expo;
    logic [51:0] frac;
    logic [63:0] raw;
    sgn  = 1'($urandom_range(1));
    raw  = {$urandom, $urandom};
    frac = raw[51:0];
    case ($urandom_range(9))
      0: return {$urandom, $urandom};
      1: begin
        expo = EXP_SPECIAL;
        if ($urandom_range(2) == 0) frac = '0;
      end
      2: begin
        expo = '0;
        if ($urandom_range(7) == 0) frac = '0;
      end
      3: expo = 11'(1023 - 70 + $urandom_range(140));
      4: begin
        expo = 11'($urandom_range(2046, 1));
        frac = '0;
      end
      5: expo = $urandom_range(1) ? 11'h7FE : 11'h001;
      default: expo = 11'($urandom_range(2046, 1));
    endcase
    return make_float(sgn, expo, frac);
  endfunction

  always @(negedge clk)
    out_tready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);

  always @(posedge clk) begin
    logic [63:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_hashes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORT)
          $display("unexpected result: hash_value=%h", out_tdata);
      end else begin
        want = pending_hashes.pop_front();
        hashes_checked++;
        if (out_tdata !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORT)
            $display("hash_value mismatch: expected %h, got %h", want, out_tdata);
        end
      end
    end
  end

  task automatic test_special_values();
    send_value(make_float(1'b0, '0, '0));
    send_value(make_float(1'b1, '0, '0));
    send_value(make_float(1'b0, EXP_SPECIAL, '0));
    send_value(make_float(1'b1, EXP_SPECIAL, '0));
    send_value(make_float(1'b0, EXP_SPECIAL, 52'h8_0000_0000_0000));
    send_value(make_float(1'b1, EXP_SPECIAL, 52'h0_0000_0000_0001));
    send_value(make_float(1'b0, EXP_SPECIAL, '1));
    send_value(make_float(1'b1, EXP_SPECIAL, '1));
  endtask

  task automatic test_extremes();
    send_value(make_float(1'b0, '0, 52'd1));
    send_value(make_float(1'b1, '0, '1));
    send_value(make_float(1'b0, 11'h001, '0));
    send_value(make_float(1'b0, 11'h7FE, '1));
    send_value(make_float(1'b1, 11'h7FE, '1));
    send_value(make_float(1'b0, 11'd1023, '0));
    // magnitude hash of one, negated: all ones minus one
    send_value(make_float(1'b1, 11'd1023, '0));
    send_value(make_float(1'b1, 11'd1084, '0));
    send_value(make_float(1'b1, '0, 52'h0_0020_0000_0000));
    send_value(make_float(1'b0, 11'd1075, '0));
    send_value(make_float(1'b0, 11'd1136, '1));
    send_value(make_float(1'b1, 11'h555, 52'hA_AAAA_AAAA_AAAA));
    send_value(make_float(1'b0, 11'h2AA, 52'h5_5555_5555_5555));
  endtask

  task automatic test_random(input int count, input int gap_pct, input int stall_pct);
    send_gap_pct   = gap_pct;
    sink_stall_pct = stall_pct;
    repeat (count) send_value(random_float());
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_gap_pct   = 28;
    sink_stall_pct = 57;
    test_special_values();
    test_extremes();
    test_random(RAND_ITEMS / 3, 28, 57);
    test_random(RAND_ITEMS / 3, 57, 28);
    test_random(RAND_ITEMS - 2 * (RAND_ITEMS / 3), 0, 0);
    in_tvalid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    $display("%0d items hashed, %0d results checked, %0d with zero or all-ones exponent",
             items_sent, hashes_checked, special_items);
    $display("directed special values and extremes, then random items under three idle mixes");
    if (mismatches == 0 && pending_hashes.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending_hashes.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/fhm61_pkg.sv
rtl/core/float_hash_mod_mersenne61.sv
rtl/core/fhm61_checker.sv
tb/tb_top.sv
